### design/assert_macros.svh
// Assertion macros shared by the waypoint steering RTL.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define WHS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define WHS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### design/whs_pkg.sv
// Package for the waypoint steering block: widths, opcodes, CORDIC table.
// Depends on nothing.
`default_nettype none
package whs_pkg;
  localparam int QueueDepth = 64;
  localparam int QW = $clog2(QueueDepth);
  localparam int CordicSteps = 16;
  localparam int SW = $clog2(CordicSteps + 1);
  // CORDIC datapath: 17 bit vector scaled by 2^16 plus growth
  localparam int CW = 36;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POS = 2'd1;
  localparam logic [1:0] OP_SPEED = 2'd2;

  localparam logic [2:0] REG_ARRIVE = 3'd0;
  localparam logic [2:0] REG_SNAP = 3'd1;
  localparam logic [2:0] REG_LIMIT = 3'd2;
  localparam logic [2:0] REG_TSLOW = 3'd3;
  localparam logic [2:0] REG_TFAST = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic reverse_flag;
    logic [15:0] speed;
  } in_word_t;

  typedef struct packed {
    logic kind;
    logic signed [15:0] steering;
    logic reverse_gear;
    logic stop;
    logic [7:0] throttle;
  } out_word_t;

  typedef struct packed {
    logic [2:0] index;
    logic [32:0] data;
  } cfg_word_t;

  // start and vector from sequencer to CORDIC
  typedef struct packed {
    logic start;
    logic signed [16:0] vy;
    logic signed [16:0] vx;
  } cordic_req_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
        5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
        5'd20: r = 32'd652;       5'd21: r = 32'd326;
        5'd22: r = 32'd163;       5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

### design/whs_if.sv
// Valid/ready channel interfaces for input, output and configuration words.
// Depends on whs_pkg.
`default_nettype none
interface whs_in_if;
  logic valid;
  logic ready;
  whs_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface whs_out_if;
  logic valid;
  logic ready;
  whs_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface whs_cfg_if;
  logic valid;
  logic ready;
  whs_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/whs_sqdist.sv
// Bit-serial squared distance: ex*ex + ey*ey by shift-and-add, one bit a cycle.
// Depends on whs_pkg.
`default_nettype none
module whs_sqdist (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic signed [16:0] ex_i,
  input  wire logic signed [16:0] ey_i,
  output logic done_o,
  output logic [33:0] d2_o
);
  import whs_pkg::*;
  `include "assert_macros.svh"

  logic [16:0] ax_q, ax_d, ay_q, ay_d;
  logic [16:0] mx_q, mx_d, my_q, my_d;
  logic [33:0] acc_q, acc_d;
  logic [4:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic [33:0] addx, addy;

  // partial products for the current multiplier bit
  always_comb begin
    addx = mx_q[0] ? {17'd0, ax_q} << cnt_q : 34'd0;
    addy = my_q[0] ? {17'd0, ay_q} << cnt_q : 34'd0;
  end

  always_comb begin
    ax_d = ax_q; ay_d = ay_q; mx_d = mx_q; my_d = my_q;
    acc_d = acc_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      ax_d = ex_i[16] ? 17'(-ex_i) : 17'(ex_i);
      ay_d = ey_i[16] ? 17'(-ey_i) : 17'(ey_i);
      mx_d = ax_d; my_d = ay_d;
      acc_d = '0; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + addx + addy;
      mx_d = mx_q >> 1; my_d = my_q >> 1;
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd16) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= ax_d; ay_q <= ay_d; mx_q <= mx_d; my_q <= my_d; acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign d2_o = acc_q;

  `WHS_ASSERT_NXT(a_sq_done, clk_i, rst_ni, busy_q && cnt_q == 5'd16, done_q && !busy_q)
  `WHS_ASSERT_IMP(a_sq_cnt, clk_i, rst_ni, busy_q, cnt_q <= 5'd16)
  `WHS_ASSERT_IMP(a_sq_idle, clk_i, rst_ni, done_q, !busy_q)
endmodule
`default_nettype wire

### design/whs_cordic.sv
// Iterative vectoring CORDIC: atan2(v, u) as 16-bit binary angle, one step a cycle.
// Depends on whs_pkg.
`default_nettype none
module whs_cordic (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire whs_pkg::cordic_req_t req_i,
  output logic done_o,
  output logic [15:0] angle_o
);
  import whs_pkg::*;
  `include "assert_macros.svh"

  logic signed [CW-1:0] a_q, a_d, b_q, b_d;
  logic [31:0] z_q, z_d;
  logic [SW-1:0] step_q, step_d;
  logic busy_q, busy_d, done_q, done_d, zero_q, zero_d;
  logic signed [CW-1:0] a0, b0, sa, sb;
  logic [31:0] zr;

  always_comb begin
    a0 = CW'(req_i.vx) <<< 16;
    b0 = CW'(req_i.vy) <<< 16;
    sa = a_q >>> step_q;
    sb = b_q >>> step_q;
    a_d = a_q; b_d = b_q; z_d = z_q; step_d = step_q;
    busy_d = busy_q; done_d = 1'b0; zero_d = zero_q;
    if (req_i.start) begin
      zero_d = (req_i.vx == '0) && (req_i.vy == '0);
      if (a0 < 0) begin
        a_d = -a0; b_d = -b0; z_d = 32'h8000_0000;
      end else begin
        a_d = a0; b_d = b0; z_d = '0;
      end
      step_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q >= 0) begin
        a_d = a_q + sb; b_d = b_q - sa; z_d = z_q + atan_turn(5'(step_q));
      end else begin
        a_d = a_q - sb; b_d = b_q + sa; z_d = z_q - atan_turn(5'(step_q));
      end
      step_d = step_q + SW'(1);
      if (step_q == SW'(CordicSteps - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; step_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; z_q <= z_d; zero_q <= zero_d;
  end

  // round to 16 bits
  assign zr = z_q + 32'h0000_8000;
  assign angle_o = zero_q ? 16'd0 : zr[31:16];
  assign done_o = done_q;

  `WHS_ASSERT_IMP(a_cd_busy, clk_i, rst_ni, done_q, !busy_q)
  `WHS_ASSERT_NXT(a_cd_end, clk_i, rst_ni,
    busy_q && !req_i.start && step_q == SW'(CordicSteps - 1), done_q)
  `WHS_ASSERT_IMP(a_cd_step, clk_i, rst_ni, busy_q, step_q < SW'(CordicSteps))
endmodule
`default_nettype wire

### design/waypoint_heading_steer.sv
// Waypoint steering top level: FIFO, sequencer, serial distance and CORDIC.
// A speed sample's word is valid the cycle after acceptance; a position sample
// that moved, with a non-empty FIFO, passes through the serial distance and then
// the two CORDIC bearings.
// One word at a time: input is held off while busy or while a result waits.
// Reset empties the FIFO, restores registers and previous position; store is not cleared.
`default_nettype none
module waypoint_heading_steer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  whs_in_if.sink in_ch,
  whs_out_if.source out_ch,
  whs_cfg_if.sink cfg_ch
);
  import whs_pkg::*;
  `include "assert_macros.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD = 3'd1;
  localparam logic [2:0] S_DIST = 3'd2;
  localparam logic [2:0] S_B1 = 3'd3;
  localparam logic [2:0] S_B2 = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] st_q, st_d;
  logic [32:0] arrive_q; logic [14:0] snap_q; logic [15:0] limit_q;
  logic [7:0] tslow_q, tfast_q;
  logic [32:0] mem_q [QueueDepth];
  logic [32:0] rd_q;
  logic [QW-1:0] head_q, tail_q;
  logic [QW:0] cnt_q;
  logic signed [15:0] prevx_q, prevy_q, px_q, py_q;
  logic ovalid_q; out_word_t odata_q;
  logic [15:0] b1_q;
  logic push_ok, acc_in, sq_start, sq_done, cd_done;
  logic [33:0] d2;
  logic [15:0] ang;
  cordic_req_t creq;
  logic signed [16:0] ex, ey;
  logic signed [15:0] tx, ty;
  logic trev, pop;
  logic [15:0] diff;
  logic signed [17:0] s0, s1;
  logic [QW:0] cnt_after;

  assign acc_in = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_q == S_IDLE) && !ovalid_q;
  assign cfg_ch.ready = 1'b1;
  assign push_ok = cnt_q < (QW+1)'(QueueDepth);

  assign tx = $signed(rd_q[32:17]);
  assign ty = $signed(rd_q[16:1]);
  assign trev = rd_q[0];
  assign ex = 17'(tx) - 17'(px_q);
  assign ey = 17'(ty) - 17'(py_q);
  assign pop = {1'b0, d2} < {2'b0, arrive_q};
  assign cnt_after = pop ? cnt_q - 1'b1 : cnt_q;
  assign sq_start = st_q == S_RD;

  whs_sqdist u_sq (.clk_i, .rst_ni, .start_i(sq_start), .ex_i(ex), .ey_i(ey),
    .done_o(sq_done), .d2_o(d2));

  // bearing request: first to target, then of travel; u = -dx
  always_comb begin
    creq.start = 1'b0; creq.vy = ey; creq.vx = -ex;
    if (st_q == S_DIST && sq_done) begin
      creq.start = 1'b1;
    end else if (st_q == S_B1 && cd_done) begin
      creq.start = 1'b1;
      creq.vy = 17'(py_q) - 17'(prevy_q);
      creq.vx = 17'(prevx_q) - 17'(px_q);
    end
  end

  whs_cordic u_cd (.clk_i, .rst_ni, .req_i(creq), .done_o(cd_done), .angle_o(ang));

  // heading error, wrap, snap, saturate, reverse
  always_comb begin
    diff = b1_q - ang;
    s0 = 18'(signed'(diff));
    if (s0 == -18'sd32768) s0 = 18'sd32768;
    if (s0 < -18'($signed({1'b0, snap_q}))) s0 = -18'sd16384;
    else if (s0 > 18'($signed({1'b0, snap_q}))) s0 = 18'sd16384;
    if (s0 > 18'sd16384) s0 = 18'sd16384;
    if (s0 < -18'sd16384) s0 = -18'sd16384;
    s1 = trev ? -s0 : s0;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (acc_in && in_ch.data.opcode == OP_POS &&
                  !(in_ch.data.pos_x == prevx_q && in_ch.data.pos_y == prevy_q) &&
                  cnt_q != '0) st_d = S_RD;
      S_RD: st_d = S_DIST;
      S_DIST: if (sq_done) st_d = S_B1;
      S_B1: if (cd_done) st_d = S_B2;
      S_B2: if (cd_done) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // FIFO storage; head entry held while a position is in work
  always_ff @(posedge clk_i) begin
    if (acc_in && in_ch.data.opcode == OP_PUSH && push_ok)
      mem_q[tail_q] <= {in_ch.data.pos_x, in_ch.data.pos_y, in_ch.data.reverse_flag};
    if (st_q == S_IDLE) rd_q <= mem_q[head_q];
    if (acc_in) begin
      px_q <= in_ch.data.pos_x; py_q <= in_ch.data.pos_y;
    end
    if (st_q == S_B1 && cd_done) b1_q <= ang;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      arrive_q <= 33'd81920; snap_q <= 15'd10650; limit_q <= 16'd2560;
      tslow_q <= 8'd153; tfast_q <= 8'd77;
      head_q <= '0; tail_q <= '0; cnt_q <= '0;
      prevx_q <= -16'sd4986; prevy_q <= -16'sd1600;
      ovalid_q <= 1'b0; odata_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.data.index)
          REG_ARRIVE: arrive_q <= cfg_ch.data.data;
          REG_SNAP: snap_q <= cfg_ch.data.data[14:0];
          REG_LIMIT: limit_q <= cfg_ch.data.data[15:0];
          REG_TSLOW: tslow_q <= cfg_ch.data.data[7:0];
          REG_TFAST: tfast_q <= cfg_ch.data.data[7:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
      if (acc_in) begin
        if (in_ch.data.opcode == OP_PUSH && push_ok) begin
          tail_q <= (tail_q == QW'(QueueDepth - 1)) ? '0 : tail_q + 1'b1;
          cnt_q <= cnt_q + 1'b1;
        end else if (in_ch.data.opcode == OP_SPEED) begin
          ovalid_q <= 1'b1;
          odata_q <= '{kind: 1'b1, steering: '0, reverse_gear: 1'b0, stop: 1'b0,
            throttle: (in_ch.data.speed >= limit_q) ? tfast_q : tslow_q};
        end else if (in_ch.data.opcode == OP_POS && cnt_q == '0) begin
          prevx_q <= in_ch.data.pos_x; prevy_q <= in_ch.data.pos_y;
        end
      end
      // arrival check once distance is ready
      if (st_q == S_DIST && sq_done) begin
        cnt_q <= cnt_after;
        if (pop) head_q <= (head_q == QW'(QueueDepth - 1)) ? '0 : head_q + 1'b1;
        odata_q.stop <= cnt_after == '0;
      end
      if (st_q == S_B2 && cd_done) begin
        prevx_q <= px_q; prevy_q <= py_q;
        ovalid_q <= 1'b1;
        odata_q.kind <= 1'b0; odata_q.steering <= s1[15:0];
        odata_q.reverse_gear <= trev; odata_q.throttle <= '0;
      end
    end
  end

  assign out_ch.valid = ovalid_q;
  assign out_ch.data = odata_q;

  `WHS_ASSERT_IMP(a_cnt_max, clk_i, rst_ni, 1'b1, cnt_q <= (QW+1)'(QueueDepth))
  `WHS_ASSERT_IMP(a_busy_noin, clk_i, rst_ni, st_q != S_IDLE, !in_ch.ready)
  `WHS_ASSERT_NXT(a_res, clk_i, rst_ni, st_q == S_B2 && cd_done, out_ch.valid)
endmodule
`default_nettype wire
